>>> design/nffe_pkg.sv
`timescale 1ns / 1ps

package nffe_pkg;

	// Field and register widths
	localparam int OUT_W              = 48;
	localparam int OUT_FRAC_BITS_DEF  = 40;
	localparam int Q2_BITS_DEF        = 32;
	localparam int OP_W               = 3;
	localparam int DMASS_W            = 20;
	localparam int MOM_W              = 32;
	localparam int MASS_W             = 20;
	localparam int MSQ_W              = 24;
	localparam int CFG_DATA_W         = 32;
	localparam int CFG_IDX_W          = 3;

	// Fixed-point scaling
	localparam int MOM_FRAC           = 28;
	localparam int MASS_FRAC          = 8;
	localparam int Q2_SHIFT           = 2 * MASS_FRAC;

	// Multiplier digit width (one digit of the second operand per stage)
	localparam int DIGIT_W            = 16;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_F1N = 3'd0;
	localparam op_t OP_F1P = 3'd1;
	localparam op_t OP_F2N = 3'd2;
	localparam op_t OP_F2P = 3'd3;
	localparam op_t OP_FS  = 3'd4;
	localparam op_t OP_FA  = 3'd5;
	localparam op_t OP_FP  = 3'd6;
	localparam op_t OP_FT  = 3'd7;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_FLAT_MODE  = 3'd0;
	localparam cfg_idx_t REG_NEUTRON_MU = 3'd1;
	localparam cfg_idx_t REG_PROTON_MU  = 3'd2;
	localparam cfg_idx_t REG_AXIAL_GA   = 3'd3;
	localparam cfg_idx_t REG_NUC_MASS   = 3'd4;
	localparam cfg_idx_t REG_NUC_MASS_SQ = 3'd5;
	localparam cfg_idx_t REG_PION_MASS  = 3'd6;

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

>>> design/nucleon_form_factor_eval_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// item      item_valid / item_stall   op, momentum_sq, dipole_mass
// result    result_valid / result_stall  form_factor, saturated
// config    wr_en (no wait)           wr_index, wr_data
//
// One transaction per cycle sustained while result_stall is low; the pipeline is 3
// front stages, the two digit-serial multipliers (ceil(width/16) stages each) and
// 49 divider stages plus the output register.
// The restoring divider, one quotient bit per stage, sets the depth.
// Reset clears valid bits and loads register defaults; no clearing pass.
// Each stage holds only while it is full and the stage after it stalls.
module nucleon_form_factor_eval_unit #(
	parameter int OUT_FRAC_BITS = nffe_pkg::OUT_FRAC_BITS_DEF,
	parameter int Q2_BITS       = nffe_pkg::Q2_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [nffe_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [nffe_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  nffe_pkg::op_t                       op,
	input  logic [Q2_BITS-1:0]                  momentum_sq,
	input  logic [nffe_pkg::DMASS_W-1:0]        dipole_mass,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [nffe_pkg::OUT_W-1:0]   form_factor,
	output logic                                saturated
);

	localparam int MW   = nffe_pkg::MOM_W;
	localparam int MF   = nffe_pkg::MOM_FRAC;
	localparam int QS   = nffe_pkg::Q2_SHIFT;
	localparam int M4W  = nffe_pkg::MSQ_W + 2;
	localparam int M2W  = nffe_pkg::MASS_W + 1;
	localparam int MR2W = 2 * nffe_pkg::DMASS_W;
	localparam int SW   = nffe_pkg::max2(MR2W, Q2_BITS + QS) + 1;
	localparam int PBW  = nffe_pkg::max2(Q2_BITS, M4W);
	localparam int PRW  = MW + PBW;
	localparam int TW0  = nffe_pkg::max2(M4W, Q2_BITS) + 1;
	localparam int BW   = nffe_pkg::max2(nffe_pkg::max2(PRW + 1, M4W + MF + 1),
		PRW + nffe_pkg::MASS_FRAC);
	localparam int DPW  = nffe_pkg::max2(TW0 + M2W + MF, SW + MF);
	localparam int DNW  = 2 * MR2W;
	localparam int WA2  = nffe_pkg::max2(BW, DPW);
	localparam int WB2  = 2 * SW;
	localparam int NW   = BW + DNW + OUT_FRAC_BITS;
	localparam int DW   = DPW + 2 * SW;
	localparam int CW   = nffe_pkg::max2(NW, DW) + 1;
	localparam int OW   = nffe_pkg::OUT_W;
	localparam int XW   = CW + OW;
	localparam int ND   = OW + 1;

	localparam logic signed [MW-1:0] MU_N_RST = -32'sd513528497;
	localparam logic signed [MW-1:0] MU_P_RST = 32'sd749699250;
	localparam logic signed [MW-1:0] GA_RST   = 32'sd341530431;
	localparam logic [nffe_pkg::MASS_W-1:0] MN_RST  = 20'd240363;
	localparam logic [nffe_pkg::MSQ_W-1:0]  MN2_RST = 24'd881571;
	localparam logic [nffe_pkg::MASS_W-1:0] MPI_RST = 20'd35730;

	// ---------------- configuration ----------------
	logic                          flat_q;
	logic signed [MW-1:0]          mun_q;
	logic signed [MW-1:0]          mup_q;
	logic signed [MW-1:0]          ga_q;
	logic [nffe_pkg::MASS_W-1:0]   mn_q;
	logic [nffe_pkg::MSQ_W-1:0]    mn2_q;
	logic [nffe_pkg::MASS_W-1:0]   mpi_q;
	logic [MR2W-1:0]               mpi2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_q <= 1'b0;
			mun_q  <= MU_N_RST;
			mup_q  <= MU_P_RST;
			ga_q   <= GA_RST;
			mn_q   <= MN_RST;
			mn2_q  <= MN2_RST;
			mpi_q  <= MPI_RST;
		end else if (wr_en) begin
			case (wr_index)
				nffe_pkg::REG_FLAT_MODE:   flat_q <= wr_data[0];
				nffe_pkg::REG_NEUTRON_MU:  mun_q  <= wr_data;
				nffe_pkg::REG_PROTON_MU:   mup_q  <= wr_data;
				nffe_pkg::REG_AXIAL_GA:    ga_q   <= wr_data;
				nffe_pkg::REG_NUC_MASS:    mn_q   <= wr_data[nffe_pkg::MASS_W-1:0];
				nffe_pkg::REG_NUC_MASS_SQ: mn2_q  <= wr_data[nffe_pkg::MSQ_W-1:0];
				nffe_pkg::REG_PION_MASS:   mpi_q  <= wr_data[nffe_pkg::MASS_W-1:0];
				default: ;
			endcase
		end
	end

	// Register the square of the current pion mass
	always_ff @(posedge clk) begin
		mpi2_q <= mpi_q * mpi_q;
	end

	logic [M4W-1:0]        m4;
	logic [M2W-1:0]        mn_x2;
	logic signed [MW:0]    mu3;
	logic [MW-1:0]         mun_mag;
	logic [MW-1:0]         mup_mag;
	logic [MW-1:0]         mu3_mag;
	logic [MW-1:0]         ga_mag;
	logic                  ga_pos;

	assign m4      = {mn2_q, 2'b00};
	assign mn_x2   = {mn_q, 1'b0};
	assign mu3     = (MW+1)'(mup_q) - ((MW+1)'(1) << MF);
	assign mun_mag = mun_q[MW-1] ? MW'(-mun_q) : MW'(mun_q);
	assign mup_mag = mup_q[MW-1] ? MW'(-mup_q) : MW'(mup_q);
	assign mu3_mag = mu3[MW] ? MW'(-mu3) : MW'(mu3);
	assign ga_mag  = ga_q[MW-1] ? MW'(-ga_q) : MW'(ga_q);
	assign ga_pos  = !ga_q[MW-1] && (ga_q != '0);

	// ---------------- front stages ----------------
	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;
	logic mul1_src_stall;

	assign en3        = !v_s3 || !mul1_src_stall;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign item_stall = !en1;

	nffe_pkg::op_t                op_s1;
	logic [Q2_BITS-1:0]           q_s1;
	logic [nffe_pkg::DMASS_W-1:0] mr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= item_valid;
		end
	end

	// Capture the transaction; flat mode drops Q2
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= op;
			q_s1  <= flat_q ? '0 : momentum_sq;
			mr_s1 <= dipole_mass;
		end
	end

	// Stage 2: dipole mass squared and the prefactor product
	logic            qz;
	logic [MR2W-1:0] mr2;
	logic [MW-1:0]   pa;
	logic [PBW-1:0]  pb;
	logic [PRW-1:0]  prod;

	assign qz   = (q_s1 == '0);
	assign mr2  = mr_s1 * mr_s1;
	assign prod = pa * pb;

	always_comb begin
		case (op_s1)
			nffe_pkg::OP_F1N: begin pa = mun_mag; pb = PBW'(q_s1);  end
			nffe_pkg::OP_F1P: begin pa = mup_mag; pb = PBW'(q_s1);  end
			nffe_pkg::OP_F2N: begin pa = mun_mag; pb = PBW'(m4);    end
			nffe_pkg::OP_F2P: begin pa = mu3_mag; pb = PBW'(m4);    end
			nffe_pkg::OP_FP:  begin pa = ga_mag;  pb = PBW'(mn_x2); end
			default:          begin pa = '0;      pb = '0;          end
		endcase
	end

	nffe_pkg::op_t      op_s2;
	logic [Q2_BITS-1:0] q_s2;
	logic               qz_s2;
	logic [MR2W-1:0]    mr2_s2;
	logic [PRW-1:0]     prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	// Zero Q2 makes the dipole exactly one
	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2   <= op_s1;
			q_s2    <= q_s1;
			qz_s2   <= qz;
			mr2_s2  <= qz ? MR2W'(1) : mr2;
			prod_s2 <= prod;
		end
	end

	// Stage 3: numerator base, denominator prefactor and dipole sum
	logic [SW-1:0]        s_c;
	logic [TW0-1:0]       tq;
	logic [TW0+M2W-1:0]   tm;
	logic [DPW-1:0]       t28;
	logic [DPW-1:0]       pion;
	logic [BW-1:0]        a54;
	logic [BW-1:0]        pr;
	logic [BW-1:0]        base_c;
	logic [DPW-1:0]       denp_c;
	logic                 neg_c;

	assign s_c  = qz_s2 ? SW'(1) : SW'(mr2_s2) + (SW'(q_s2) << QS);
	assign tq   = TW0'(m4) + TW0'(q_s2);
	assign tm   = tq * mn_x2;
	assign t28  = DPW'(tq) << MF;
	assign pion = (DPW'(mpi2_q) + (DPW'(q_s2) << QS)) << MF;
	assign a54  = BW'(m4) << MF;
	assign pr   = BW'(prod_s2);

	always_comb begin
		base_c = '0;
		denp_c = DPW'(1);
		neg_c  = 1'b0;
		case (op_s2)
			nffe_pkg::OP_F1N: begin
				base_c = pr;
				neg_c  = mun_q[MW-1];
				denp_c = t28;
			end
			nffe_pkg::OP_F1P: begin
				denp_c = t28;
				if (!mup_q[MW-1]) begin
					base_c = a54 + pr;
				end else if (a54 >= pr) begin
					base_c = a54 - pr;
				end else begin
					base_c = pr - a54;
					neg_c  = 1'b1;
				end
			end
			nffe_pkg::OP_F2N: begin
				base_c = pr << nffe_pkg::MASS_FRAC;
				neg_c  = mun_q[MW-1];
				denp_c = DPW'(tm) << MF;
			end
			nffe_pkg::OP_F2P: begin
				base_c = pr << nffe_pkg::MASS_FRAC;
				neg_c  = mu3[MW];
				denp_c = DPW'(tm) << MF;
			end
			nffe_pkg::OP_FA: begin
				base_c = BW'(ga_mag);
				neg_c  = ga_pos;
				denp_c = DPW'(1) << MF;
			end
			nffe_pkg::OP_FP: begin
				base_c = pr << nffe_pkg::MASS_FRAC;
				neg_c  = ga_pos;
				denp_c = pion;
			end
			default: ;
		endcase
	end

	logic [BW-1:0]    base_s3;
	logic [DPW-1:0]   denp_s3;
	logic             neg_s3;
	logic [MR2W-1:0]  mr2_s3;
	logic [SW-1:0]    s_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			base_s3 <= base_c;
			denp_s3 <= denp_c;
			neg_s3  <= neg_c;
			mr2_s3  <= mr2_s2;
			s_s3    <= s_c;
		end
	end

	// ---------------- dipole squares ----------------
	logic                 m1_valid;
	logic                 mul2_src_stall;
	logic [2*SW-1:0]      m1_xp;
	logic [2*SW-1:0]      m1_yp;
	logic [BW+DPW:0]      m1_side;
	logic                 m1_neg;
	logic [BW-1:0]        m1_base;
	logic [DPW-1:0]       m1_denp;

	nffe_mul #(
		.WA(SW), .WB(SW), .SIDE_W(BW + DPW + 1)
	) u_mul_sq (
		.clk(clk), .arst_n(arst_n),
		.src_valid(v_s3), .src_stall(mul1_src_stall),
		.x_a(SW'(mr2_s3)), .x_b(SW'(mr2_s3)),
		.y_a(s_s3), .y_b(s_s3),
		.src_side({neg_s3, base_s3, denp_s3}),
		.dst_valid(m1_valid), .dst_stall(mul2_src_stall),
		.x_p(m1_xp), .y_p(m1_yp), .dst_side(m1_side)
	);

	assign {m1_neg, m1_base, m1_denp} = m1_side;

	// ---------------- numerator and denominator ----------------
	logic                 m2_valid;
	logic                 div_stall;
	logic [WA2+WB2-1:0]   m2_xp;
	logic [WA2+WB2-1:0]   m2_yp;
	logic                 m2_neg;

	nffe_mul #(
		.WA(WA2), .WB(WB2), .SIDE_W(1)
	) u_mul_nd (
		.clk(clk), .arst_n(arst_n),
		.src_valid(m1_valid), .src_stall(mul2_src_stall),
		.x_a(WA2'(m1_base)), .x_b(m1_xp),
		.y_a(WA2'(m1_denp)), .y_b(m1_yp),
		.src_side(m1_neg),
		.dst_valid(m2_valid), .dst_stall(div_stall),
		.x_p(m2_xp), .y_p(m2_yp), .dst_side(m2_neg)
	);

	// ---------------- restoring divider ----------------
	logic [NW-1:0] nnum;
	logic [DW-1:0] dden;
	logic          ovf0;

	assign nnum = {m2_xp[BW+DNW-1:0], {OUT_FRAC_BITS{1'b0}}};
	assign dden = m2_yp[DW-1:0];
	// Quotient of 2^48 or more always clips
	assign ovf0 = CW'(nnum >> OW) >= CW'(dden);

	logic          vd_s  [ND];
	logic [NW-1:0] r_s   [ND];
	logic [DW-1:0] d_s   [ND];
	logic [OW-1:0] qt_s  [ND];
	logic          ovf_s [ND];
	logic          nz_s  [ND];
	logic          neg_s [ND];
	logic [ND:0]   en_d;
	logic          en_o;
	logic          vo_q;

	assign en_d[ND]  = en_o;
	assign div_stall = !en_d[0];

	for (genvar j = 0; j < ND; j++) begin : g_div
		logic          v_in;
		logic [NW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [OW-1:0] q_in;
		logic          ovf_in;
		logic          nz_in;
		logic          neg_in;

		assign en_d[j] = !vd_s[j] || en_d[j+1];

		if (j == 0) begin : g_load
			assign v_in   = m2_valid;
			assign r_in   = nnum;
			assign d_in   = dden;
			assign q_in   = '0;
			assign ovf_in = ovf0;
			assign nz_in  = (nnum != '0);
			assign neg_in = m2_neg;
		end else begin : g_bit
			localparam int BI = OW - j;
			logic ge;

			// Subtract the shifted divisor where it fits
			assign ge     = CW'(r_s[j-1] >> BI) >= CW'(d_s[j-1]);
			assign v_in   = vd_s[j-1];
			assign r_in   = ge ? r_s[j-1] - NW'(XW'(d_s[j-1]) << BI) : r_s[j-1];
			assign d_in   = d_s[j-1];
			assign q_in   = qt_s[j-1] | (OW'(ge) << BI);
			assign ovf_in = ovf_s[j-1];
			assign nz_in  = nz_s[j-1];
			assign neg_in = neg_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[j] <= 1'b0;
			end else if (en_d[j]) begin
				vd_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_d[j]) begin
				r_s[j]   <= r_in;
				d_s[j]   <= d_in;
				qt_s[j]  <= q_in;
				ovf_s[j] <= ovf_in;
				nz_s[j]  <= nz_in;
				neg_s[j] <= neg_in;
			end
		end
	end

	// ---------------- saturate, sign and output register ----------------
	logic [OW-1:0] lim;
	logic [OW-1:0] mag;
	logic          sat_c;
	logic [OW-1:0] val_c;

	assign lim   = neg_s[ND-1] ? (OW'(1) << (OW - 1)) : ((OW'(1) << (OW - 1)) - OW'(1));
	assign sat_c = nz_s[ND-1] && (ovf_s[ND-1] || (qt_s[ND-1] > lim));
	assign mag   = sat_c ? lim : qt_s[ND-1];
	assign val_c = !nz_s[ND-1] ? '0 : (neg_s[ND-1] ? OW'(-mag) : mag);
	assign en_o  = !vo_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en_o) begin
			vo_q <= vd_s[ND-1];
		end
	end

	// Hold the result while stalled
	always_ff @(posedge clk) begin
		if (en_o) begin
			form_factor <= val_c;
			saturated   <= sat_c;
		end
	end

	assign result_valid = vo_q;

endmodule

>>> design/nffe_mul.sv
`timescale 1ns / 1ps

// Two-lane pipelined multiplier: one DG-bit digit of the second operand per stage.
module nffe_mul #(
	parameter int WA     = 8,
	parameter int WB     = 8,
	parameter int SIDE_W = 1,
	parameter int DG     = nffe_pkg::DIGIT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  logic [WA-1:0]     x_a,
	input  logic [WB-1:0]     x_b,
	input  logic [WA-1:0]     y_a,
	input  logic [WB-1:0]     y_b,
	input  logic [SIDE_W-1:0] src_side,
	output logic              dst_valid,
	input  logic              dst_stall,
	output logic [WA+WB-1:0]  x_p,
	output logic [WA+WB-1:0]  y_p,
	output logic [SIDE_W-1:0] dst_side
);

	localparam int NS  = (WB + DG - 1) / DG;
	localparam int BPW = NS * DG;
	localparam int PW  = WA + WB;

	logic              v_s    [NS];
	logic [WA-1:0]     xa_s   [NS];
	logic [WA-1:0]     ya_s   [NS];
	logic [BPW-1:0]    xb_s   [NS];
	logic [BPW-1:0]    yb_s   [NS];
	logic [PW-1:0]     xp_s   [NS];
	logic [PW-1:0]     yp_s   [NS];
	logic [SIDE_W-1:0] side_s [NS];
	logic [NS:0]       en;

	// Advance a stage when it is empty or the next one advances
	assign en[NS] = !dst_stall;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic              v_in;
		logic [WA-1:0]     xa_in;
		logic [WA-1:0]     ya_in;
		logic [BPW-1:0]    xb_in;
		logic [BPW-1:0]    yb_in;
		logic [PW-1:0]     xp_in;
		logic [PW-1:0]     yp_in;
		logic [SIDE_W-1:0] sd_in;
		logic [WA+DG-1:0]  xm;
		logic [WA+DG-1:0]  ym;

		assign en[k] = !v_s[k] || en[k+1];

		if (k == 0) begin : g_first
			assign v_in  = src_valid;
			assign xa_in = x_a;
			assign ya_in = y_a;
			assign xb_in = BPW'(x_b);
			assign yb_in = BPW'(y_b);
			assign xp_in = '0;
			assign yp_in = '0;
			assign sd_in = src_side;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign xa_in = xa_s[k-1];
			assign ya_in = ya_s[k-1];
			assign xb_in = xb_s[k-1];
			assign yb_in = yb_s[k-1];
			assign xp_in = xp_s[k-1];
			assign yp_in = yp_s[k-1];
			assign sd_in = side_s[k-1];
		end

		// Partial product of this digit
		assign xm = xa_in * xb_in[k*DG +: DG];
		assign ym = ya_in * yb_in[k*DG +: DG];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_in;
			end
		end

		// Accumulate the shifted partial product
		always_ff @(posedge clk) begin
			if (en[k]) begin
				xa_s[k]   <= xa_in;
				ya_s[k]   <= ya_in;
				xb_s[k]   <= xb_in;
				yb_s[k]   <= yb_in;
				xp_s[k]   <= xp_in + (PW'(xm) << (k * DG));
				yp_s[k]   <= yp_in + (PW'(ym) << (k * DG));
				side_s[k] <= sd_in;
			end
		end
	end

	assign src_stall = !en[0];
	assign dst_valid = v_s[NS-1];
	assign x_p       = xp_s[NS-1];
	assign y_p       = yp_s[NS-1];
	assign dst_side  = side_s[NS-1];

endmodule

>>> design/nffe_chk.sv
`timescale 1ns / 1ps

module nffe_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_valid,
	input logic                              item_stall,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic signed [nffe_pkg::OUT_W-1:0] form_factor,
	input logic                              saturated
);

	localparam logic [nffe_pkg::OUT_W-1:0] POS_LIM = {1'b0, {(nffe_pkg::OUT_W-1){1'b1}}};
	localparam logic [nffe_pkg::OUT_W-1:0] NEG_LIM = {1'b1, {(nffe_pkg::OUT_W-1){1'b0}}};

	// A stalled transaction stays and keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(form_factor)
			&& $stable(saturated))
		else $error("stalled result changed");

	// A clipped result sits at one of the range limits
	a_sat_lim: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> form_factor == POS_LIM || form_factor == NEG_LIM)
		else $error("saturated result off the limit");

	// An empty output never backs up the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with empty output");

	// Nothing comes out right after reset
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid out of reset");

	// An offered result carries known values
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$isunknown({form_factor, saturated}))
		else $error("unknown result value");

endmodule

bind nucleon_form_factor_eval_unit nffe_chk u_nffe_chk (.*);
